[src/ebs_pkg.sv]
// Shared types and constants of the eyelid blink sequencer.
// Used by ebs_ctrl, ebs_dp and the eyelid_blink_sequencer top level.
`timescale 1ns / 1ps

package ebs_pkg;

  // Fixed-point layout: lid factor in Q1.15, 32768 is fully closed
  localparam int FRAC_BITS = 15;
  localparam int T_W       = 15;
  localparam int LEN_W     = 21;
  localparam int DLY_W     = 25;
  localparam int DIV_STEPS = 15;

  localparam logic [15:0] ONE_Q     = 16'h8000;
  localparam logic [15:0] WIDEN_TOL = 16'd32;

  // Command codes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_BLINK   = 3'd1;
  localparam logic [2:0] OP_CLOSE   = 3'd2;
  localparam logic [2:0] OP_WIDEN   = 3'd3;
  localparam logic [2:0] OP_NORMAL  = 3'd4;
  localparam logic [2:0] OP_SET_GAP = 3'd5;

  // Lid modes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_CLOSING  = 3'd1;
  localparam logic [2:0] MODE_OPENING  = 3'd2;
  localparam logic [2:0] MODE_F_CLOSE  = 3'd3;
  localparam logic [2:0] MODE_F_WIDEN  = 3'd4;
  localparam logic [2:0] MODE_F_NORMAL = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_INT_MIN    = 3'd0;
  localparam logic [2:0] REG_INT_SPAN   = 3'd1;
  localparam logic [2:0] REG_CLOSE_MIN  = 3'd2;
  localparam logic [2:0] REG_CLOSE_SPAN = 3'd3;
  localparam logic [2:0] REG_OPEN_MIN   = 3'd4;
  localparam logic [2:0] REG_OPEN_SPAN  = 3'd5;
  localparam logic [2:0] REG_PAUSE      = 3'd6;
  localparam logic [2:0] REG_FORCED     = 3'd7;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_START_BLINK,
    ACT_F_CLOSE,
    ACT_F_WIDEN,
    ACT_F_NORMAL,
    ACT_SET_GAP,
    ACT_END_HOLD,
    ACT_END_NORMAL,
    ACT_RAMP,
    ACT_PAUSE_HOLD,
    ACT_TO_OPEN,
    ACT_TO_IDLE
  } act_t;

  typedef enum logic [1:0] {
    DRAW_CLOSE,
    DRAW_OPEN,
    DRAW_INTERVAL
  } draw_t;

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_SM,
    MUL_LERP,
    MUL_DRAW
  } mul_t;

  typedef struct packed {
    logic  capture;
    logic  apply;
    act_t  act;
    draw_t draw_sel;
    logic  mul_go;
    mul_t  mul_sel;
    logic  div_load;
    logic  div_step;
    logic  use_smooth;
    logic  out_load;
    logic  changed;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] mode;
    logic       forced;
    logic       dt_ge_len;
    logic       due;
    logic       pause_hold;
    logic       widen_same;
  } sts_t;

endpackage

[src/ebs_ctrl.sv]
// Sequencing state machine of the eyelid blink sequencer.
// Depends on ebs_pkg; drives ebs_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module ebs_ctrl #(
  parameter bit USE_SMOOTHSTEP = 1'b1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  ebs_pkg::sts_t sts,
  output ebs_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DRAW,
    S_APPLY,
    S_BLINK_EVAL,
    S_DIV,
    S_SQ,
    S_SM,
    S_LERP,
    S_RAMP,
    S_DONE
  } state_t;

  state_t         state_r, state_nxt;
  ebs_pkg::act_t  act_r, act_nxt;
  ebs_pkg::draw_t draw_r, draw_nxt;
  logic           changed_r, changed_nxt;
  logic           smooth_r, smooth_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           forced_mode;

  assign forced_mode = (sts.mode == ebs_pkg::MODE_F_CLOSE) ||
                       (sts.mode == ebs_pkg::MODE_F_WIDEN) ||
                       (sts.mode == ebs_pkg::MODE_F_NORMAL);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and per-cycle commands
  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    draw_nxt    = draw_r;
    changed_nxt = changed_r;
    smooth_nxt  = smooth_r;
    cnt_nxt     = cnt_r;

    cmd            = '0;
    cmd.act        = ebs_pkg::ACT_NONE;
    cmd.draw_sel   = draw_r;
    cmd.mul_sel    = ebs_pkg::MUL_SQ;
    cmd.use_smooth = smooth_r;
    cmd.changed    = changed_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        changed_nxt = 1'b0;
        state_nxt   = S_DONE;
        case (sts.op)
          ebs_pkg::OP_TICK: begin
            if (forced_mode) begin
              if (sts.dt_ge_len) begin
                if (sts.mode == ebs_pkg::MODE_F_NORMAL) begin
                  draw_nxt    = ebs_pkg::DRAW_INTERVAL;
                  act_nxt     = ebs_pkg::ACT_END_NORMAL;
                  changed_nxt = 1'b1;
                  state_nxt   = S_DRAW;
                end else begin
                  cmd.apply = 1'b1;
                  cmd.act   = ebs_pkg::ACT_END_HOLD;
                end
              end else begin
                cmd.div_load = 1'b1;
                smooth_nxt   = 1'b1;
                changed_nxt  = 1'b1;
                cnt_nxt      = '0;
                state_nxt    = S_DIV;
              end
            end else if (sts.forced) begin
              state_nxt = S_DONE;
            end else if (sts.mode == ebs_pkg::MODE_IDLE && sts.due) begin
              draw_nxt  = ebs_pkg::DRAW_CLOSE;
              act_nxt   = ebs_pkg::ACT_START_BLINK;
              state_nxt = S_DRAW;
            end else begin
              state_nxt = S_BLINK_EVAL;
            end
          end
          ebs_pkg::OP_BLINK: begin
            draw_nxt  = ebs_pkg::DRAW_CLOSE;
            act_nxt   = ebs_pkg::ACT_START_BLINK;
            state_nxt = S_DRAW;
          end
          ebs_pkg::OP_CLOSE: begin
            if (sts.mode != ebs_pkg::MODE_F_CLOSE) begin
              cmd.apply = 1'b1;
              cmd.act   = ebs_pkg::ACT_F_CLOSE;
            end
          end
          ebs_pkg::OP_WIDEN: begin
            if (!sts.widen_same) begin
              cmd.apply = 1'b1;
              cmd.act   = ebs_pkg::ACT_F_WIDEN;
            end
          end
          ebs_pkg::OP_NORMAL: begin
            if (sts.mode != ebs_pkg::MODE_F_NORMAL && sts.forced) begin
              cmd.apply = 1'b1;
              cmd.act   = ebs_pkg::ACT_F_NORMAL;
            end
          end
          ebs_pkg::OP_SET_GAP: begin
            cmd.apply = 1'b1;
            cmd.act   = ebs_pkg::ACT_SET_GAP;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_DRAW: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = ebs_pkg::MUL_DRAW;
        state_nxt   = S_APPLY;
      end

      S_APPLY: begin
        cmd.apply = 1'b1;
        cmd.act   = act_r;
        if (sts.op == ebs_pkg::OP_TICK && act_r == ebs_pkg::ACT_START_BLINK) begin
          state_nxt = S_BLINK_EVAL;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Advance a blink that is closing or opening
      S_BLINK_EVAL: begin
        state_nxt = S_DONE;
        if (sts.mode == ebs_pkg::MODE_CLOSING || sts.mode == ebs_pkg::MODE_OPENING) begin
          changed_nxt = 1'b1;
          if (sts.dt_ge_len) begin
            if (sts.mode == ebs_pkg::MODE_CLOSING) begin
              if (sts.pause_hold) begin
                cmd.apply = 1'b1;
                cmd.act   = ebs_pkg::ACT_PAUSE_HOLD;
              end else begin
                draw_nxt  = ebs_pkg::DRAW_OPEN;
                act_nxt   = ebs_pkg::ACT_TO_OPEN;
                state_nxt = S_DRAW;
              end
            end else begin
              draw_nxt  = ebs_pkg::DRAW_INTERVAL;
              act_nxt   = ebs_pkg::ACT_TO_IDLE;
              state_nxt = S_DRAW;
            end
          end else begin
            cmd.div_load = 1'b1;
            smooth_nxt   = USE_SMOOTHSTEP;
            cnt_nxt      = '0;
            state_nxt    = S_DIV;
          end
        end
      end

      // One quotient bit per cycle
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == 4'(ebs_pkg::DIV_STEPS - 1)) begin
          state_nxt = smooth_r ? S_SQ : S_LERP;
        end
      end

      S_SQ: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = ebs_pkg::MUL_SQ;
        state_nxt   = S_SM;
      end

      S_SM: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = ebs_pkg::MUL_SM;
        state_nxt   = S_LERP;
      end

      S_LERP: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = ebs_pkg::MUL_LERP;
        state_nxt   = S_RAMP;
      end

      S_RAMP: begin
        cmd.apply = 1'b1;
        cmd.act   = ebs_pkg::ACT_RAMP;
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  // Hold state and registered controls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= ebs_pkg::ACT_NONE;
      draw_r      <= ebs_pkg::DRAW_CLOSE;
      changed_r   <= 1'b0;
      smooth_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      draw_r      <= draw_nxt;
      changed_r   <= changed_nxt;
      smooth_r    <= smooth_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/ebs_dp.sv]
// Datapath of the eyelid blink sequencer: configuration, lid state,
// serial divider, shared multiplier and output register. Depends on ebs_pkg.
`timescale 1ns / 1ps

module ebs_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_wdata,
  input  logic [2:0]    in_op,
  input  logic [31:0]   in_now_us,
  input  logic [15:0]   in_gap,
  input  logic [15:0]   in_rand_draw,
  output logic [15:0]   out_lid_factor,
  output logic          out_changed,
  output logic [2:0]    out_mode,
  input  ebs_pkg::cmd_t cmd,
  output ebs_pkg::sts_t sts
);

  // Configuration registers
  logic [23:0] int_min_r, int_span_r;
  logic [19:0] close_min_r, close_span_r, open_min_r, open_span_r;
  logic [19:0] pause_r, forced_r;

  // Captured item
  logic [2:0]  op_r;
  logic [31:0] now_r;
  logic [15:0] gap_r;
  logic [15:0] rand_r;

  // Lid state
  logic [2:0]                  mode_r;
  logic [15:0]                 factor_r, rest_r, ramp_from_r, ramp_to_r;
  logic                        forced_r_flag;
  logic [31:0]                 phase_start_r;
  logic [ebs_pkg::LEN_W-1:0]   len_r;
  logic [ebs_pkg::DLY_W-1:0]   delay_r;

  // Divider and multiplier
  logic [ebs_pkg::LEN_W-1:0]   rem_r;
  logic [ebs_pkg::T_W-1:0]     t_r;
  logic [40:0]                 prod_r;

  // Output register
  logic [15:0] out_lid_r;
  logic        out_changed_r;
  logic [2:0]  out_mode_r;

  logic [31:0]               dt;
  logic [15:0]               gap_sat, wdiff;
  logic [23:0]               draw_min, draw_span;
  logic [ebs_pkg::DLY_W-1:0] draw_val;
  logic [15:0]               lp_from, lp_to, lp_diff;
  logic                      lp_up;
  logic [16:0]               lp_step;
  logic [15:0]               lerp_val;
  logic [23:0]               mul_a;
  logic [16:0]               mul_b;
  logic [ebs_pkg::LEN_W:0]   rem_sh;
  logic                      rem_ge;

  assign gap_sat = (in_gap > ebs_pkg::ONE_Q) ? ebs_pkg::ONE_Q : in_gap;
  assign dt      = now_r - phase_start_r;
  assign wdiff   = (ramp_to_r >= gap_r) ? (ramp_to_r - gap_r) : (gap_r - ramp_to_r);

  // Status toward the controller
  always_comb begin
    sts.op         = op_r;
    sts.mode       = mode_r;
    sts.forced     = forced_r_flag;
    sts.dt_ge_len  = dt >= 32'(len_r);
    sts.due        = dt >= 32'(delay_r);
    sts.pause_hold = (pause_r != '0) && (dt < (32'(len_r) + 32'(pause_r)));
    sts.widen_same = (mode_r == ebs_pkg::MODE_F_WIDEN) && (wdiff <= ebs_pkg::WIDEN_TOL);
  end

  // Random draw: min + ((rand * span) >> 16)
  always_comb begin
    case (cmd.draw_sel)
      ebs_pkg::DRAW_CLOSE: begin
        draw_min  = 24'(close_min_r);
        draw_span = 24'(close_span_r);
      end
      ebs_pkg::DRAW_OPEN: begin
        draw_min  = 24'(open_min_r);
        draw_span = 24'(open_span_r);
      end
      default: begin
        draw_min  = int_min_r;
        draw_span = int_span_r;
      end
    endcase
    draw_val = ebs_pkg::DLY_W'(draw_min) + prod_r[40:16];
  end

  // Interpolation endpoints follow the mode
  always_comb begin
    case (mode_r)
      ebs_pkg::MODE_CLOSING: begin
        lp_from = rest_r;
        lp_to   = ebs_pkg::ONE_Q;
      end
      ebs_pkg::MODE_OPENING: begin
        lp_from = ebs_pkg::ONE_Q;
        lp_to   = rest_r;
      end
      default: begin
        lp_from = ramp_from_r;
        lp_to   = ramp_to_r;
      end
    endcase
    lp_up    = lp_to >= lp_from;
    lp_diff  = lp_up ? (lp_to - lp_from) : (lp_from - lp_to);
    lp_step  = prod_r[31:15];
    lerp_val = lp_up ? (lp_from + lp_step[15:0]) : (lp_from - lp_step[15:0]);
  end

  // Shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      ebs_pkg::MUL_SQ: begin
        mul_a = 24'(t_r);
        mul_b = 17'(t_r);
      end
      ebs_pkg::MUL_SM: begin
        mul_a = 24'(prod_r[29:15]);
        mul_b = 17'd98304 - {1'b0, t_r, 1'b0};
      end
      ebs_pkg::MUL_LERP: begin
        mul_a = 24'(lp_diff);
        mul_b = cmd.use_smooth ? prod_r[31:15] : 17'(t_r);
      end
      default: begin
        mul_a = draw_span;
        mul_b = 17'(rand_r);
      end
    endcase
  end

  // Restoring divide step
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, len_r};

  // Configuration, item capture and arithmetic registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_min_r    <= 24'd2000000;
      int_span_r   <= 24'd6000000;
      close_min_r  <= 20'd50000;
      close_span_r <= 20'd50000;
      open_min_r   <= 20'd100000;
      open_span_r  <= 20'd100000;
      pause_r      <= 20'd0;
      forced_r     <= 20'd150000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ebs_pkg::REG_INT_MIN:    int_min_r    <= cfg_wdata;
        ebs_pkg::REG_INT_SPAN:   int_span_r   <= cfg_wdata;
        ebs_pkg::REG_CLOSE_MIN:  close_min_r  <= cfg_wdata[19:0];
        ebs_pkg::REG_CLOSE_SPAN: close_span_r <= cfg_wdata[19:0];
        ebs_pkg::REG_OPEN_MIN:   open_min_r   <= cfg_wdata[19:0];
        ebs_pkg::REG_OPEN_SPAN:  open_span_r  <= cfg_wdata[19:0];
        ebs_pkg::REG_PAUSE:      pause_r      <= cfg_wdata[19:0];
        ebs_pkg::REG_FORCED:     forced_r     <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      now_r  <= in_now_us;
      gap_r  <= gap_sat;
      rand_r <= in_rand_draw;
    end
    if (cmd.mul_go) begin
      prod_r <= 41'(mul_a) * 41'(mul_b);
    end
    if (cmd.div_load) begin
      rem_r <= dt[ebs_pkg::LEN_W-1:0];
      t_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? ebs_pkg::LEN_W'(rem_sh - {1'b0, len_r}) : rem_sh[ebs_pkg::LEN_W-1:0];
      t_r   <= {t_r[ebs_pkg::T_W-2:0], rem_ge};
    end
    if (cmd.out_load) begin
      out_lid_r     <= factor_r;
      out_mode_r    <= mode_r;
      out_changed_r <= cmd.changed;
    end
  end

  // Lid state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= ebs_pkg::MODE_IDLE;
      factor_r      <= '0;
      rest_r        <= '0;
      forced_r_flag <= 1'b0;
      ramp_from_r   <= '0;
      ramp_to_r     <= '0;
      phase_start_r <= '0;
      len_r         <= '0;
      delay_r       <= ebs_pkg::DLY_W'(24'd2000000);
    end else if (cmd.apply) begin
      case (cmd.act) inside
        ebs_pkg::ACT_START_BLINK: begin
          mode_r        <= ebs_pkg::MODE_CLOSING;
          forced_r_flag <= 1'b0;
          phase_start_r <= now_r;
          len_r         <= draw_val[ebs_pkg::LEN_W-1:0];
        end
        ebs_pkg::ACT_F_CLOSE, ebs_pkg::ACT_F_WIDEN, ebs_pkg::ACT_F_NORMAL: begin
          forced_r_flag <= 1'b1;
          ramp_from_r   <= factor_r;
          len_r         <= ebs_pkg::LEN_W'(forced_r);
          phase_start_r <= now_r;
          if (cmd.act == ebs_pkg::ACT_F_CLOSE) begin
            ramp_to_r <= ebs_pkg::ONE_Q;
            mode_r    <= ebs_pkg::MODE_F_CLOSE;
          end else if (cmd.act == ebs_pkg::ACT_F_WIDEN) begin
            ramp_to_r <= gap_r;
            mode_r    <= ebs_pkg::MODE_F_WIDEN;
          end else begin
            ramp_to_r <= rest_r;
            mode_r    <= ebs_pkg::MODE_F_NORMAL;
          end
        end
        ebs_pkg::ACT_SET_GAP: begin
          rest_r <= gap_r;
          if (mode_r == ebs_pkg::MODE_IDLE) begin
            factor_r <= gap_r;
          end
        end
        ebs_pkg::ACT_END_HOLD: begin
          factor_r <= ramp_to_r;
        end
        ebs_pkg::ACT_END_NORMAL: begin
          factor_r      <= ramp_to_r;
          mode_r        <= ebs_pkg::MODE_IDLE;
          forced_r_flag <= 1'b0;
          phase_start_r <= now_r;
          delay_r       <= draw_val;
        end
        ebs_pkg::ACT_RAMP: begin
          factor_r <= lerp_val;
        end
        ebs_pkg::ACT_PAUSE_HOLD: begin
          factor_r <= ebs_pkg::ONE_Q;
        end
        ebs_pkg::ACT_TO_OPEN: begin
          mode_r        <= ebs_pkg::MODE_OPENING;
          phase_start_r <= now_r;
          len_r         <= draw_val[ebs_pkg::LEN_W-1:0];
          factor_r      <= ebs_pkg::ONE_Q;
        end
        ebs_pkg::ACT_TO_IDLE: begin
          mode_r   <= ebs_pkg::MODE_IDLE;
          factor_r <= rest_r;
          delay_r  <= draw_val;
        end
        default: ;
      endcase
    end
  end

  assign out_lid_factor = out_lid_r;
  assign out_changed    = out_changed_r;
  assign out_mode       = out_mode_r;

endmodule

[src/eyelid_blink_sequencer.sv]
// Top level of the eyelid blink sequencer.
// Depends on ebs_pkg, ebs_ctrl and ebs_dp.
`timescale 1ns / 1ps

// The block takes one timestamped command at a time and returns one result
// item per command. A command that only changes state is decoded and, where it
// needs a random time, passes through the draw and apply states; a tick that
// starts a blink with zero closing time draws the opening time as well. A tick
// that interpolates the lid runs the serial divider for the 15-bit phase
// fraction and then the shared multiplier: three passes (square, smoothstep,
// lerp) for a forced ramp and for a blink ramp with smoothstep, and only the
// lerp pass for a blink ramp without smoothstep. Stalls on the result side
// hold a finished command until the output register is free. A new item is
// taken as soon as the previous one has moved into the output register, even
// while that result still waits.

module eyelid_blink_sequencer #(
  parameter bit USE_SMOOTHSTEP = 1'b1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_now_us,
  input  logic [15:0] in_gap,
  input  logic [15:0] in_rand_draw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_lid_factor,
  output logic        out_changed,
  output logic [2:0]  out_mode
);

  ebs_pkg::cmd_t cmd;
  ebs_pkg::sts_t sts;

  ebs_ctrl #(
    .USE_SMOOTHSTEP(USE_SMOOTHSTEP)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ebs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_op),
    .in_now_us      (in_now_us),
    .in_gap         (in_gap),
    .in_rand_draw   (in_rand_draw),
    .out_lid_factor (out_lid_factor),
    .out_changed    (out_changed),
    .out_mode       (out_mode),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
